// ----- rtl/tcp_rto_pkg.sv -----
package tcp_rto_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int OUT_W     = 32;
    localparam int GRAN_W    = 20;
    localparam int TMO_W     = 26;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT = 2'd2;

    localparam logic [GRAN_W-1:0] GRAN_RST = 20'd4000;
    localparam logic [TMO_W-1:0]  MIN_RST  = 26'd200000;
    localparam logic [TMO_W-1:0]  INIT_RST = 26'd1000000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_RND_SUB,
        ST_RND_ADD,
        ST_SEED,
        ST_DIFF,
        ST_ABS,
        ST_DEV_MUL,
        ST_DEV_ADD,
        ST_SRTT_MUL,
        ST_SRTT_ADD,
        ST_TOI,
        ST_CEIL,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/tcp_rto_estimator.sv -----
// TCP retransmission timeout estimator.
// Input channel: i_valid / o_ready carry one RTT sample word (microseconds).
// Output channel: o_valid / i_ready carry one result word per sample: the
// timeout, the updated smoothed RTT and deviation, and first/saturated flags.
// A zero sample restarts the estimator and returns the initial timeout.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 granularity, 1 minimum timeout, 2 initial timeout); write only when idle.
// One sample at a time. A bit-serial remainder unit (one bit per cycle over
// a DW = max(32, TIME_BITS+4) bit dividend) runs twice per sample, once to
// round the sample and once to round the timeout; one shared adder does the
// remaining steps. The first sample seeds the estimate and skips the update
// steps; a zero sample skips all of them and goes straight to the output.
// A finished word waits in the output register while the next sample is
// already accepted and worked on; the sequencer holds in its last step until
// the receiver has taken the previous word.
// Reset (synchronous, i_rst_n low) clears the estimate, drops o_valid and
// loads the configuration defaults 4000, 200000 and 1000000 us.
module tcp_rto_estimator
    import tcp_rto_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter int FRAC_BITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [TMO_W-1:0]      i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SAMPLE_W-1:0]   i_rtt_sample_us,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_W-1:0]      o_timeout_us,
    output logic                  o_was_first_sample,
    output logic [OUT_W-1:0]      o_smoothed_rtt_us,
    output logic [OUT_W-1:0]      o_rtt_deviation_us,
    output logic                  o_saturated
);

    localparam int SW  = TIME_BITS + FRAC_BITS;
    localparam int AW0 = (SW + 3 > TIME_BITS + 4) ? SW + 3 : TIME_BITS + 4;
    localparam int AW  = (AW0 > OUT_W + 1) ? AW0 : OUT_W + 1;
    localparam int DW  = (TIME_BITS + 4 > SAMPLE_W) ? TIME_BITS + 4 : SAMPLE_W;
    localparam int CW  = $clog2(DW);

    localparam logic [AW-1:0] TIME_MAX  = (AW'(1) << TIME_BITS) - AW'(1);
    localparam logic [AW-1:0] FRAC_MASK = (AW'(1) << FRAC_BITS) - AW'(1);
    localparam logic [CW-1:0] CNT_TOP   = CW'(DW - 1);

    t_state             r_state, n_state;

    logic [GRAN_W-1:0]  r_gran;
    logic [TMO_W-1:0]   r_min;
    logic [TMO_W-1:0]   r_init;

    logic [SW-1:0]      r_srtt;
    logic [SW-1:0]      r_dev;
    logic               r_have;

    logic [DW-1:0]      r_num;
    logic [GRAN_W-1:0]  r_rem;
    logic [CW-1:0]      r_cnt;
    logic               r_phase;
    logic [AW-1:0]      r_acc;
    logic [SW-1:0]      r_sfx;
    logic [SW-1:0]      r_diff;
    logic               r_first;
    logic               r_restart;

    logic               r_o_valid;
    logic [OUT_W-1:0]   r_o_tmo;
    logic               r_o_first;
    logic [OUT_W-1:0]   r_o_srtt;
    logic [OUT_W-1:0]   r_o_dev;
    logic               r_o_sat;

    logic [GRAN_W-1:0]  g_eff;
    logic [GRAN_W:0]    div_cand;
    logic               div_ge;
    logic [GRAN_W-1:0]  div_rem;

    logic [AW-1:0]      alu_a, alu_b, alu_sum;
    logic               alu_sub;

    logic [AW-1:0]      gfx, dev_x4, spread;
    logic [AW-1:0]      s_clamp, s_shift;
    logic [AW-1:0]      rto_c;
    logic [SW-1:0]      srtt_int, dev_int;
    logic               out_load;
    logic               accept;

    assign g_eff   = (r_gran == '0) ? GRAN_W'(1) : r_gran;
    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE);
    assign out_load = (r_state == ST_DONE) && (!r_o_valid || i_ready);

    // remainder unit, one dividend bit per cycle
    assign div_cand = {r_rem, r_num[r_cnt]};
    assign div_ge   = div_cand >= {1'b0, g_eff};
    assign div_rem  = div_ge ? GRAN_W'(div_cand - {1'b0, g_eff}) : div_cand[GRAN_W-1:0];

    assign gfx     = AW'(g_eff) << FRAC_BITS;
    assign dev_x4  = AW'(r_dev) << 2;
    assign spread  = (gfx > dev_x4) ? gfx : dev_x4;
    assign s_clamp = (r_acc > TIME_MAX) ? TIME_MAX : r_acc;
    assign s_shift = s_clamp << FRAC_BITS;
    assign rto_c   = (r_acc < AW'(r_min)) ? AW'(r_min) : r_acc;
    assign srtt_int = r_srtt >> FRAC_BITS;
    assign dev_int  = r_dev >> FRAC_BITS;

    assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_rtt_sample_us == '0) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_RND_SUB;
                end
            end
            ST_RND_SUB:  n_state = ST_RND_ADD;
            ST_RND_ADD:  n_state = r_phase ? ST_DONE : ST_SEED;
            ST_SEED:     n_state = r_have ? ST_DIFF : ST_TOI;
            ST_DIFF:     n_state = ST_ABS;
            ST_ABS:      n_state = ST_DEV_MUL;
            ST_DEV_MUL:  n_state = ST_DEV_ADD;
            ST_DEV_ADD:  n_state = ST_SRTT_MUL;
            ST_SRTT_MUL: n_state = ST_SRTT_ADD;
            ST_SRTT_ADD: n_state = ST_TOI;
            ST_TOI:      n_state = ST_CEIL;
            ST_CEIL:     n_state = ST_DIV;
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            ST_RND_SUB: begin
                alu_a   = AW'(r_num);
                alu_b   = AW'(r_rem);
                alu_sub = 1'b1;
            end
            ST_RND_ADD: begin
                alu_a = r_acc;
                alu_b = (r_rem != '0) ? AW'(g_eff) : '0;
            end
            ST_DIFF: begin
                alu_a   = AW'(r_srtt);
                alu_b   = AW'(r_sfx);
                alu_sub = 1'b1;
            end
            ST_ABS: begin
                alu_a   = r_acc[AW-1] ? '0 : r_acc;
                alu_b   = r_acc[AW-1] ? r_acc : '0;
                alu_sub = r_acc[AW-1];
            end
            ST_DEV_MUL: begin
                alu_a = AW'(r_dev) << 1;
                alu_b = AW'(r_dev);
            end
            ST_DEV_ADD: begin
                alu_a = r_acc;
                alu_b = AW'(r_diff);
            end
            ST_SRTT_MUL: begin
                alu_a   = AW'(r_srtt) << 3;
                alu_b   = AW'(r_srtt);
                alu_sub = 1'b1;
            end
            ST_SRTT_ADD: begin
                alu_a = r_acc;
                alu_b = AW'(r_sfx);
            end
            ST_TOI: begin
                alu_a = AW'(r_srtt);
                alu_b = spread;
            end
            ST_CEIL: begin
                alu_a = r_acc >> FRAC_BITS;
                alu_b = AW'((r_acc & FRAC_MASK) != '0);
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_gran  <= GRAN_RST;
            r_min   <= MIN_RST;
            r_init  <= INIT_RST;
            r_srtt  <= '0;
            r_dev   <= '0;
            r_have  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GRAN: r_gran <= i_cfg_data[GRAN_W-1:0];
                    CFG_MIN:  r_min  <= i_cfg_data;
                    CFG_INIT: r_init <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (accept && i_rtt_sample_us == '0) begin
                r_srtt <= '0;
                r_dev  <= '0;
                r_have <= 1'b0;
            end
            if (r_state == ST_SEED && !r_have) begin
                r_srtt <= SW'(s_shift);
                r_dev  <= SW'(s_shift >> 1);
                r_have <= 1'b1;
            end
            if (r_state == ST_DEV_ADD) begin
                r_dev <= SW'(alu_sum >> 2);
            end
            if (r_state == ST_SRTT_ADD) begin
                r_srtt <= SW'(alu_sum >> 3);
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_num     <= DW'(i_rtt_sample_us);
                r_rem     <= '0;
                r_cnt     <= CNT_TOP;
                r_phase   <= 1'b0;
                r_first   <= 1'b0;
                r_restart <= (i_rtt_sample_us == '0);
            end
            ST_DIV: begin
                r_rem <= div_rem;
                r_cnt <= r_cnt - CW'(1);
            end
            ST_SEED: begin
                r_sfx   <= SW'(s_shift);
                r_first <= !r_have;
            end
            ST_DEV_MUL: begin
                r_diff <= SW'(r_acc);
                r_acc  <= alu_sum;
            end
            ST_CEIL: begin
                r_num   <= DW'(alu_sum);
                r_rem   <= '0;
                r_cnt   <= CNT_TOP;
                r_phase <= 1'b1;
            end
            ST_DONE: begin
                r_acc <= r_acc;
            end
            default: begin
                r_acc <= alu_sum;
            end
        endcase
        if (out_load) begin
            if (r_restart) begin
                r_o_tmo   <= OUT_W'(r_init);
                r_o_first <= 1'b0;
                r_o_srtt  <= '0;
                r_o_dev   <= '0;
                r_o_sat   <= 1'b0;
            end else begin
                r_o_tmo   <= (rto_c[AW-1:OUT_W] != '0) ? '1 : rto_c[OUT_W-1:0];
                r_o_first <= r_first;
                r_o_srtt  <= OUT_W'(srtt_int);
                r_o_dev   <= OUT_W'(dev_int);
                r_o_sat   <= (rto_c[AW-1:OUT_W] != '0);
            end
        end
    end

    assign o_valid            = r_o_valid;
    assign o_timeout_us       = r_o_tmo;
    assign o_was_first_sample = r_o_first;
    assign o_smoothed_rtt_us  = r_o_srtt;
    assign o_rtt_deviation_us = r_o_dev;
    assign o_saturated        = r_o_sat;

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_timeout_us == '1)
        else $error("saturated word without clipped timeout");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_rem < g_eff)
        else $error("remainder not below granularity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_state != ST_IDLE)
        else $error("sample accepted without starting work");

endmodule
